FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/prll_pkg.sv
package prll_pkg;

  // Field widths of the item and result beats.
  localparam int HEIGHT_W = 8;
  localparam int PIN_W    = 8;
  localparam int DRIVE_W  = 12;
  localparam int FRAC_W   = 4;
  localparam int SUM_W    = 14;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 12'd4095;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_SAMPLE      = 2'd0,
    REQ_LOAD_TARGET = 2'd1,
    REQ_SET_PIN     = 2'd2,
    REQ_PRESENCE    = 2'd3
  } req_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_SPEED       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOAD_FRAMES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_FRAMES    = 2'd3;

  localparam logic [CFG_W-1:0] LOAD_SPEED_RST       = 8'd48;
  localparam logic [CFG_W-1:0] SETTLE_THRESHOLD_RST = 8'd13;
  localparam logic [CFG_W-1:0] MAX_LOAD_FRAMES_RST  = 8'd93;
  localparam logic [CFG_W-1:0] ADJUST_FRAMES_RST    = 8'd30;

  // One pin's stored state.
  typedef struct packed {
    logic [DRIVE_W-1:0]  drive;
    logic [HEIGHT_W-1:0] target;
    logic                present;
  } pin_entry_t;

  localparam int ENTRY_W = $bits(pin_entry_t);

  // Every pin starts at 50.0 with a target of 50 and is present.
  localparam pin_entry_t ENTRY_RESET = '{drive: 12'd800, target: 8'd50, present: 1'b1};

  // Item fields that the per-pin update needs.
  typedef struct packed {
    req_t                req;
    logic [HEIGHT_W-1:0] height;
    logic                pin_present;
  } pin_req_t;

  // Block-wide state and settings seen by the per-pin update.
  typedef struct packed {
    logic              loading;
    logic              adjusting;
    logic [CFG_W-1:0]  load_speed;
    logic [CFG_W-1:0]  settle_threshold;
  } calc_ctrl_t;

  // Result of the per-pin update.
  typedef struct packed {
    pin_entry_t entry;
    logic       moving;
  } calc_res_t;

  // Saturate a signed sum to the drive range.
  function automatic logic [DRIVE_W-1:0] clamp_drive(input logic signed [SUM_W-1:0] v);
    logic [DRIVE_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({2'b00, DRIVE_MAX})) begin
      r = DRIVE_MAX;
    end else begin
      r = v[DRIVE_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/pin_array_rate_limited_loader.sv
// Pin array loader: keeps a Q8.4 drive height, a target and a presence bit for
// each of PIN_COUNT pins in one memory and returns one result beat per input
// beat. A new item can be taken while the last one is in the compute stage
// unless the output stalls: an item reads its pin's entry as it is accepted,
// the update is computed in the following cycle and written back while the
// result enters the output register, and a one-entry bypass covers a beat for
// the same pin right behind. The single read port and single write port of the
// pin memory allow this. After reset the memory is cleared to its start values,
// during which in_stall stays high; configuration writes are taken at any time.
module pin_array_rate_limited_loader #(
  parameter int PIN_COUNT      = 144,
  parameter int FOLLOW_DIVISOR = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_req_type,
  input  logic [prll_pkg::PIN_W-1:0]         in_pin_index,
  input  logic [prll_pkg::HEIGHT_W-1:0]      in_height_value,
  input  logic                               in_pin_present,
  input  logic                               in_frame_end,
  input  logic                               in_begin_loading,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [prll_pkg::PIN_W-1:0]         out_pin,
  output logic [prll_pkg::HEIGHT_W-1:0]      out_drive_height,
  output logic                               out_is_loading,
  output logic                               out_is_adjusting,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [prll_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prll_pkg::CFG_W-1:0]         cfg_data
);

  localparam int ADDR_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIN_COUNT - 1);

  // Configuration registers.
  logic [prll_pkg::CFG_W-1:0] load_speed_r;
  logic [prll_pkg::CFG_W-1:0] settle_threshold_r;
  logic [prll_pkg::CFG_W-1:0] max_load_frames_r;
  logic [prll_pkg::CFG_W-1:0] adjust_frames_r;

  // Block-wide loading state.
  logic                       loading_r, loading_nxt;
  logic [7:0]                 adjust_count_r, adjust_count_nxt;
  logic [7:0]                 load_frames_r, load_frames_nxt;
  logic                       still_moving_r, still_moving_nxt;

  // Clearing pass.
  logic                       clr_active_r;
  logic [ADDR_W-1:0]          clr_addr_r;

  // Compute stage.
  logic                       s1_valid_r;
  prll_pkg::req_t             s1_req_r;
  logic [prll_pkg::PIN_W-1:0] s1_pin_r;
  logic [prll_pkg::HEIGHT_W-1:0] s1_height_r;
  logic                       s1_present_r;
  logic                       s1_fend_r;
  logic                       s1_begin_r;
  logic                       s1_inrange_r;
  logic                       byp_hit_r;
  prll_pkg::pin_entry_t       byp_entry_r;

  // Output register.
  logic                       out_valid_r;
  logic [prll_pkg::PIN_W-1:0] out_pin_r;
  logic [prll_pkg::HEIGHT_W-1:0] out_drive_r;
  logic                       out_loading_r;
  logic                       out_adjusting_r;

  logic                       in_accept;
  logic                       s1_adv;
  logic                       s1_wr;
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  prll_pkg::pin_entry_t       ram_wdata;
  prll_pkg::pin_entry_t       ram_rdata;
  prll_pkg::pin_entry_t       cur_entry;
  prll_pkg::pin_req_t         calc_req;
  prll_pkg::calc_ctrl_t       calc_ctrl;
  prll_pkg::calc_res_t        calc_res;
  logic                       is_sample;
  logic                       moving_now;
  logic [7:0]                 frames_inc;
  logic [7:0]                 adjust_inc;

  // Handshakes.
  assign cfg_ready = rst_n;
  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = !rst_n || clr_active_r || (s1_valid_r && !s1_adv);
  assign in_accept = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_speed_r       <= prll_pkg::LOAD_SPEED_RST;
      settle_threshold_r <= prll_pkg::SETTLE_THRESHOLD_RST;
      max_load_frames_r  <= prll_pkg::MAX_LOAD_FRAMES_RST;
      adjust_frames_r    <= prll_pkg::ADJUST_FRAMES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        prll_pkg::CFG_LOAD_SPEED:       load_speed_r       <= cfg_data;
        prll_pkg::CFG_SETTLE_THRESHOLD: settle_threshold_r <= cfg_data;
        prll_pkg::CFG_MAX_LOAD_FRAMES:  max_load_frames_r  <= cfg_data;
        prll_pkg::CFG_ADJUST_FRAMES:    adjust_frames_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Clearing pass over the pin memory after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == LAST_ADDR) begin
        clr_active_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Pin memory: read on acceptance, written back from the compute stage.
  assign s1_wr     = s1_adv && s1_inrange_r;
  assign ram_we    = clr_active_r || s1_wr;
  assign ram_waddr = clr_active_r ? clr_addr_r : ADDR_W'(s1_pin_r);
  assign ram_wdata = clr_active_r ? prll_pkg::ENTRY_RESET : calc_res.entry;

  prll_ram #(
    .WIDTH (prll_pkg::ENTRY_W),
    .DEPTH (PIN_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (ADDR_W'(in_pin_index)),
    .rdata (ram_rdata)
  );

  // Compute stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Capture the beat, and the entry being written now if it is the same pin.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r     <= prll_pkg::req_t'(in_req_type);
      s1_pin_r     <= in_pin_index;
      s1_height_r  <= in_height_value;
      s1_present_r <= in_pin_present;
      s1_fend_r    <= in_frame_end;
      s1_begin_r   <= in_begin_loading;
      s1_inrange_r <= (32'(in_pin_index) < PIN_COUNT);
      byp_hit_r    <= s1_wr && (s1_pin_r == in_pin_index);
      byp_entry_r  <= calc_res.entry;
    end
  end

  assign cur_entry = byp_hit_r ? byp_entry_r : ram_rdata;

  assign calc_req.req         = s1_req_r;
  assign calc_req.height      = s1_height_r;
  assign calc_req.pin_present = s1_present_r;

  assign calc_ctrl.loading          = loading_r;
  assign calc_ctrl.adjusting        = (adjust_count_r != 8'd0);
  assign calc_ctrl.load_speed       = load_speed_r;
  assign calc_ctrl.settle_threshold = settle_threshold_r;

  prll_pin_calc #(
    .FOLLOW_DIVISOR (FOLLOW_DIVISOR)
  ) u_calc (
    .req   (calc_req),
    .entry (cur_entry),
    .ctrl  (calc_ctrl),
    .res   (calc_res)
  );

  // Frame bookkeeping and the start of loading.
  assign is_sample  = (s1_req_r == prll_pkg::REQ_SAMPLE);
  assign moving_now = still_moving_r || (is_sample && s1_inrange_r && calc_res.moving);
  assign frames_inc = (load_frames_r != 8'hFF) ? load_frames_r + 8'd1 : load_frames_r;
  assign adjust_inc = adjust_count_r + 8'd1;

  always_comb begin
    loading_nxt      = loading_r;
    adjust_count_nxt = adjust_count_r;
    load_frames_nxt  = load_frames_r;
    still_moving_nxt = moving_now;
    case (s1_req_r)
      prll_pkg::REQ_SAMPLE: begin
        if (s1_fend_r) begin
          if (loading_r) begin
            if (adjust_count_r == 8'd0) begin
              load_frames_nxt = frames_inc;
              if (!moving_now || (frames_inc > max_load_frames_r)) begin
                adjust_count_nxt = 8'd1;
              end
            end else if (adjust_inc >= adjust_frames_r) begin
              adjust_count_nxt = 8'd0;
              loading_nxt      = 1'b0;
            end else begin
              adjust_count_nxt = adjust_inc;
            end
          end
          still_moving_nxt = 1'b0;
        end
      end
      prll_pkg::REQ_LOAD_TARGET, prll_pkg::REQ_SET_PIN: begin
        if (s1_begin_r) begin
          loading_nxt      = 1'b1;
          load_frames_nxt  = 8'd0;
          adjust_count_nxt = 8'd0;
          still_moving_nxt = 1'b0;
        end
      end
      default: begin
        still_moving_nxt = still_moving_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loading_r      <= 1'b1;
      adjust_count_r <= 8'd0;
      load_frames_r  <= 8'd0;
      still_moving_r <= 1'b0;
    end else if (s1_adv) begin
      loading_r      <= loading_nxt;
      adjust_count_r <= adjust_count_nxt;
      load_frames_r  <= load_frames_nxt;
      still_moving_r <= still_moving_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pin_r       <= s1_pin_r;
      out_drive_r     <= s1_inrange_r
                       ? calc_res.entry.drive[prll_pkg::DRIVE_W-1:prll_pkg::FRAC_W]
                       : '0;
      out_loading_r   <= loading_nxt;
      out_adjusting_r <= (adjust_count_nxt != 8'd0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pin          = out_pin_r;
  assign out_drive_height = out_drive_r;
  assign out_is_loading   = out_loading_r;
  assign out_is_adjusting = out_adjusting_r;

endmodule

FILE: rtl/prll_ram.sv
module prll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port; a read at the written
  // address returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/prll_pin_calc.sv
module prll_pin_calc #(
  parameter int FOLLOW_DIVISOR = 4
) (
  input  prll_pkg::pin_req_t   req,
  input  prll_pkg::pin_entry_t entry,
  input  prll_pkg::calc_ctrl_t ctrl,
  output prll_pkg::calc_res_t  res
);

  // Division by the follow divisor as a multiply by a rounded-up reciprocal;
  // exact for 8-bit magnitudes and divisors below 256.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = prll_pkg::HEIGHT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + FOLLOW_DIVISOR - 1) / FOLLOW_DIVISOR);

  logic [prll_pkg::HEIGHT_W-1:0]        drv_int;
  logic signed [prll_pkg::HEIGHT_W+1:0] fol_diff;
  logic                                 fol_neg;
  logic [prll_pkg::HEIGHT_W-1:0]        fol_mag;
  logic [PROD_W-1:0]                    fol_prod;
  logic [prll_pkg::HEIGHT_W-1:0]        fol_q;
  logic signed [prll_pkg::SUM_W-1:0]    fol_step;
  logic signed [prll_pkg::SUM_W-1:0]    fol_sum;
  logic [prll_pkg::DRIVE_W-1:0]         fol_drive;
  logic signed [prll_pkg::HEIGHT_W+1:0] tdiff;
  logic signed [prll_pkg::SUM_W-1:0]    tdiff16;
  logic signed [prll_pkg::HEIGHT_W+1:0] fdiff;
  logic [prll_pkg::HEIGHT_W-1:0]        fdiff_mag;
  logic signed [prll_pkg::SUM_W-1:0]    spd;
  logic signed [prll_pkg::SUM_W-1:0]    step_add;
  logic signed [prll_pkg::SUM_W-1:0]    step_sum;
  logic [prll_pkg::DRIVE_W-1:0]         step_drive;
  logic                                 follow_en;
  logic                                 step_en;
  logic [prll_pkg::DRIVE_W-1:0]         smp_drive;

  assign drv_int = entry.drive[prll_pkg::DRIVE_W-1:prll_pkg::FRAC_W];

  // Follow: drive moves by (measured - drive) / divisor, truncated toward zero.
  assign fol_diff  = $signed({2'b00, req.height}) - $signed({2'b00, drv_int});
  assign fol_neg   = fol_diff < 0;
  assign fol_mag   = fol_neg ? prll_pkg::HEIGHT_W'(-fol_diff)
                             : prll_pkg::HEIGHT_W'(fol_diff);
  assign fol_prod  = PROD_W'(fol_mag) * PROD_W'(RECIP);
  assign fol_q     = fol_prod[RECIP_SHIFT +: prll_pkg::HEIGHT_W];
  assign fol_step  = $signed({2'b00, fol_q, 4'b0000});
  assign fol_sum   = $signed({2'b00, entry.drive}) + (fol_neg ? -fol_step : fol_step);
  assign fol_drive = prll_pkg::clamp_drive(fol_sum);

  // Step: move toward the target, at most by the load speed along fdiff.
  assign tdiff     = $signed({2'b00, entry.target}) - $signed({2'b00, drv_int});
  assign tdiff16   = $signed({tdiff, 4'b0000});
  assign fdiff     = $signed({2'b00, entry.target}) - $signed({2'b00, req.height});
  assign fdiff_mag = (fdiff < 0) ? prll_pkg::HEIGHT_W'(-fdiff)
                                 : prll_pkg::HEIGHT_W'(fdiff);
  assign spd       = $signed({6'b000000, ctrl.load_speed});

  always_comb begin
    if (fdiff > 0) begin
      step_add = (spd < tdiff16) ? spd : tdiff16;
    end else if (fdiff < 0) begin
      step_add = (-spd > tdiff16) ? -spd : tdiff16;
    end else begin
      step_add = '0;
    end
  end

  assign step_sum   = $signed({2'b00, entry.drive}) + step_add;
  assign step_drive = prll_pkg::clamp_drive(step_sum);

  assign follow_en = !ctrl.loading || ctrl.adjusting;
  assign step_en   = ctrl.loading && !ctrl.adjusting && entry.present;
  assign smp_drive = follow_en ? fol_drive : (step_en ? step_drive : entry.drive);

  // New entry according to the request type.
  always_comb begin
    res.entry  = entry;
    res.moving = 1'b0;
    case (req.req)
      prll_pkg::REQ_SAMPLE: begin
        res.entry.drive = smp_drive;
        if (!ctrl.loading) begin
          res.entry.target = smp_drive[prll_pkg::DRIVE_W-1:prll_pkg::FRAC_W];
        end
        res.moving = step_en && (fdiff_mag >= ctrl.settle_threshold);
      end
      prll_pkg::REQ_LOAD_TARGET: begin
        res.entry.target = req.height;
      end
      prll_pkg::REQ_SET_PIN: begin
        res.entry.target = req.height;
        res.entry.drive  = {req.height, 4'b0000};
      end
      prll_pkg::REQ_PRESENCE: begin
        res.entry.present = req.pin_present;
      end
      default: begin
        res.entry = entry;
      end
    endcase
  end

endmodule

FILE: rtl/prll_checker.sv
`include "assert_macros.svh"

module prll_checker #(
  parameter int PIN_COUNT = 144
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [prll_pkg::PIN_W-1:0]    out_pin,
  input logic [prll_pkg::HEIGHT_W-1:0] out_drive_height,
  input logic                          out_is_loading,
  input logic                          out_is_adjusting
);

  // The whole result payload, and whether its pin lies beyond the array.
  logic [prll_pkg::PIN_W+prll_pkg::HEIGHT_W+1:0] out_word;
  logic                                          out_far;

  assign out_word = {out_pin, out_drive_height, out_is_loading, out_is_adjusting};
  assign out_far  = (32'(out_pin) >= PIN_COUNT);

  // A stalled result beat holds.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))

  // The adjust phase only exists inside loading.
  `ASSERT_SAME(a_adjust_in_loading, clk, rst_n, out_valid && out_is_adjusting, out_is_loading)

  // A pin beyond the array reports a zero drive.
  `ASSERT_SAME(a_range_zero, clk, rst_n, out_valid && out_far, out_drive_height == '0)

  // The memory clearing pass holds off input right after reset.
  `ASSERT_SAME(a_clear_stall, clk, rst_n, !$past(rst_n), in_stall)

endmodule

bind pin_array_rate_limited_loader prll_checker #(
  .PIN_COUNT (PIN_COUNT)
) u_prll_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pin          (out_pin),
  .out_drive_height (out_drive_height),
  .out_is_loading   (out_is_loading),
  .out_is_adjusting (out_is_adjusting)
);

FILE: tb/pin_array_rate_limited_loader_test.sv
module pin_array_rate_limited_loader_test;

  localparam int PIN_TOTAL  = 144;
  localparam int FOLLOW_DIV = 4;
  localparam int RUN_LIMIT  = 2000000;

  // One expected result beat.
  typedef struct {
    logic [prll_pkg::PIN_W-1:0]    pin;
    logic [prll_pkg::HEIGHT_W-1:0] drive;
    logic                          loading;
    logic                          adjusting;
  } pin_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = prll_pkg::REQ_SAMPLE;
  logic [prll_pkg::PIN_W-1:0] in_pin_index = '0;
  logic [prll_pkg::HEIGHT_W-1:0] in_height_value = '0;
  logic in_pin_present = 1'b0;
  logic in_frame_end = 1'b0;
  logic in_begin_loading = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [prll_pkg::PIN_W-1:0] out_pin;
  logic [prll_pkg::HEIGHT_W-1:0] out_drive_height;
  logic out_is_loading;
  logic out_is_adjusting;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [prll_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [prll_pkg::CFG_W-1:0] cfg_data = '0;

  // Mirror of the pin array and of the frame bookkeeping.
  logic [prll_pkg::DRIVE_W-1:0]  drive_mirror [PIN_TOTAL];
  logic [prll_pkg::HEIGHT_W-1:0] target_mirror [PIN_TOTAL];
  logic                          present_mirror [PIN_TOTAL];
  logic                          loading_mirror;
  logic [7:0]                    adjust_mirror;
  logic [7:0]                    frame_count_mirror;
  logic                          moving_mirror;

  // Mirror of the configuration registers.
  logic [prll_pkg::CFG_W-1:0] speed_set;
  logic [prll_pkg::CFG_W-1:0] threshold_set;
  logic [prll_pkg::CFG_W-1:0] frame_limit_set;
  logic [prll_pkg::CFG_W-1:0] adjust_len_set;

  pin_result_t pending_pin_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int results_checked = 0;
  int settings_count = 0;
  int mismatches = 0;

  pin_array_rate_limited_loader #(
    .PIN_COUNT(PIN_TOTAL),
    .FOLLOW_DIVISOR(FOLLOW_DIV)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_pin_index(in_pin_index),
    .in_height_value(in_height_value),
    .in_pin_present(in_pin_present),
    .in_frame_end(in_frame_end),
    .in_begin_loading(in_begin_loading),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pin(out_pin),
    .out_drive_height(out_drive_height),
    .out_is_loading(out_is_loading),
    .out_is_adjusting(out_is_adjusting),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Saturate a drive sum to the Q8.4 range.
  function automatic logic [prll_pkg::DRIVE_W-1:0] sat_drive(input int v);
    if (v < 0) return '0;
    if (v > 4095) return 12'hFFF;
    return 12'(v);
  endfunction

  // Pin choice: mostly a small cluster so pins are revisited, rarely out of range.
  function automatic logic [prll_pkg::PIN_W-1:0] pick_pin();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 8'($urandom_range(PIN_TOTAL, 255));
    if (r < 70) return 8'($urandom_range(0, 11));
    return 8'($urandom_range(0, PIN_TOTAL - 1));
  endfunction

  // Measured height: mostly near the target so pins can settle.
  function automatic logic [prll_pkg::HEIGHT_W-1:0] pick_height(
      input logic [prll_pkg::PIN_W-1:0] p);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (p >= PIN_TOTAL || r >= 80) return 8'($urandom_range(0, 255));
    if (r >= 60) return drive_mirror[p][prll_pkg::DRIVE_W-1:prll_pkg::FRAC_W];
    v = int'(target_mirror[p]) + int'($urandom_range(0, 40)) - 20;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // Apply one accepted item to the mirror and queue the result it causes.
  task automatic update_pin_model(input prll_pkg::req_t rt,
                                  input logic [prll_pkg::PIN_W-1:0] pin,
                                  input logic [prll_pkg::HEIGHT_W-1:0] h, input logic pres,
                                  input logic fend, input logic bgn);
    int d;
    int delta;
    int tgt;
    int fdiff;
    int tdiff16;
    int spd;
    int afd;
    logic was_loading;
    logic hit;
    pin_result_t r;
    hit = pin < PIN_TOTAL;
    case (rt)
      prll_pkg::REQ_SAMPLE: begin
        was_loading = loading_mirror;
        if (hit) begin
          d = drive_mirror[pin];
          // Outside the step phase the drive follows the measurement.
          if (!was_loading || adjust_mirror != 0) begin
            delta = (int'(h) - (d >>> 4)) / FOLLOW_DIV;
            d = sat_drive(d + delta * 16);
          end
          // In the step phase a present pin moves toward its target.
          if (was_loading && adjust_mirror == 0 && present_mirror[pin]) begin
            tgt = target_mirror[pin];
            fdiff = tgt - int'(h);
            tdiff16 = (tgt - (d >>> 4)) * 16;
            spd = speed_set;
            afd = (fdiff < 0) ? -fdiff : fdiff;
            if (afd >= int'(threshold_set)) moving_mirror = 1'b1;
            if (fdiff > 0) begin
              d = sat_drive(d + ((spd < tdiff16) ? spd : tdiff16));
            end else if (fdiff < 0) begin
              d = sat_drive(d + ((-spd > tdiff16) ? -spd : tdiff16));
            end
          end
          drive_mirror[pin] = 12'(d);
          if (!was_loading) begin
            target_mirror[pin] = drive_mirror[pin][prll_pkg::DRIVE_W-1:prll_pkg::FRAC_W];
          end
        end
        // Frame end decides whether loading or the adjust phase ends.
        if (fend) begin
          if (loading_mirror) begin
            if (adjust_mirror == 0) begin
              if (frame_count_mirror != 8'd255) frame_count_mirror = frame_count_mirror + 8'd1;
              if (!moving_mirror || frame_count_mirror > frame_limit_set) adjust_mirror = 8'd1;
            end else begin
              adjust_mirror = adjust_mirror + 8'd1;
              if (adjust_mirror >= adjust_len_set) begin
                adjust_mirror = 8'd0;
                loading_mirror = 1'b0;
              end
            end
          end
          moving_mirror = 1'b0;
        end
      end
      prll_pkg::REQ_LOAD_TARGET, prll_pkg::REQ_SET_PIN: begin
        if (hit) begin
          target_mirror[pin] = h;
          if (rt == prll_pkg::REQ_SET_PIN) drive_mirror[pin] = {h, 4'b0000};
        end
        if (bgn) begin
          loading_mirror = 1'b1;
          frame_count_mirror = 8'd0;
          adjust_mirror = 8'd0;
          moving_mirror = 1'b0;
        end
      end
      default: begin
        if (hit) present_mirror[pin] = pres;
      end
    endcase
    r.pin = pin;
    r.drive = '0;
    if (hit) r.drive = drive_mirror[pin][prll_pkg::DRIVE_W-1:prll_pkg::FRAC_W];
    r.loading = loading_mirror;
    r.adjusting = adjust_mirror != 0;
    pending_pin_results.insert(pending_pin_results.size(), r);
  endtask

  // Send one item beat, with a random idle gap before it.
  task automatic send_item(input prll_pkg::req_t rt, input logic [prll_pkg::PIN_W-1:0] pin,
                           input logic [prll_pkg::HEIGHT_W-1:0] h, input logic pres,
                           input logic fend, input logic bgn);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_pin_index <= pin;
    in_height_value <= h;
    in_pin_present <= pres;
    in_frame_end <= fend;
    in_begin_loading <= bgn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    update_pin_model(rt, pin, h, pres, fend, bgn);
    items_sent++;
  endtask

  // Hold off the sender until every expected result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pin_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one configuration register.
  task automatic write_reg(input logic [prll_pkg::CFG_IDX_W-1:0] idx,
                           input logic [prll_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      prll_pkg::CFG_LOAD_SPEED:       speed_set = val;
      prll_pkg::CFG_SETTLE_THRESHOLD: threshold_set = val;
      prll_pkg::CFG_MAX_LOAD_FRAMES:  frame_limit_set = val;
      default:                        adjust_len_set = val;
    endcase
  endtask

  // Drain, write all four registers, then start a fresh loading session.
  task automatic apply_settings(input int speed, input int thresh, input int frame_limit,
                                input int adj_len);
    logic [prll_pkg::PIN_W-1:0] p;
    wait_for_results();
    write_reg(prll_pkg::CFG_LOAD_SPEED, 8'(speed));
    write_reg(prll_pkg::CFG_SETTLE_THRESHOLD, 8'(thresh));
    write_reg(prll_pkg::CFG_MAX_LOAD_FRAMES, 8'(frame_limit));
    write_reg(prll_pkg::CFG_ADJUST_FRAMES, 8'(adj_len));
    settings_count++;
    p = pick_pin();
    send_item(prll_pkg::REQ_LOAD_TARGET, p, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
  endtask

  // Random traffic: mostly short frame scans, plus target loads, presence writes and noise.
  task automatic run_traffic(input int n_items);
    int stop_at;
    int kind;
    int n;
    int i;
    logic [prll_pkg::PIN_W-1:0] p;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) begin
          p = pick_pin();
          send_item(prll_pkg::REQ_SAMPLE, p, pick_height(p), 1'($urandom_range(0, 1)),
                    i == n - 1, 1'($urandom_range(0, 1)));
        end
      end else if (kind < 85) begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          send_item(($urandom_range(0, 1) != 0) ? prll_pkg::REQ_SET_PIN
                                                : prll_pkg::REQ_LOAD_TARGET, pick_pin(),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)),
                    (i == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0));
        end
      end else if (kind < 92) begin
        send_item(prll_pkg::REQ_PRESENCE, pick_pin(), 8'($urandom_range(0, 255)),
                  $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        send_item(prll_pkg::req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Directed items under reset settings: extremes, every request and the odd cases.
  task automatic test_directed_items();
    send_item(prll_pkg::REQ_SAMPLE, 8'd0, 8'd50, 1'b0, 1'b0, 1'b0);
    send_item(prll_pkg::REQ_LOAD_TARGET, 8'd0, 8'd255, 1'b0, 1'b0, 1'b0);
    send_item(prll_pkg::REQ_SAMPLE, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
    // Frame end on a write is ignored; begin restarts the loading.
    send_item(prll_pkg::REQ_LOAD_TARGET, 8'd143, 8'd0, 1'b0, 1'b1, 1'b1);
    send_item(prll_pkg::REQ_SAMPLE, 8'd143, 8'd255, 1'b0, 1'b0, 1'b0);
    send_item(prll_pkg::REQ_SET_PIN, 8'd5, 8'd255, 1'b0, 1'b0, 1'b0);
    send_item(prll_pkg::REQ_SAMPLE, 8'd5, 8'd255, 1'b1, 1'b0, 1'b0);
    send_item(prll_pkg::REQ_SET_PIN, 8'd6, 8'd0, 1'b0, 1'b0, 1'b0);
    send_item(prll_pkg::REQ_SAMPLE, 8'd6, 8'd0, 1'b0, 1'b0, 1'b0);
    // An absent pin does not step while loading.
    send_item(prll_pkg::REQ_PRESENCE, 8'd7, 8'd0, 1'b0, 1'b0, 1'b0);
    send_item(prll_pkg::REQ_LOAD_TARGET, 8'd7, 8'd200, 1'b0, 1'b0, 1'b0);
    send_item(prll_pkg::REQ_SAMPLE, 8'd7, 8'd0, 1'b0, 1'b0, 1'b0);
    send_item(prll_pkg::REQ_PRESENCE, 8'd7, 8'd255, 1'b1, 1'b1, 1'b1);
    send_item(prll_pkg::REQ_SAMPLE, 8'd7, 8'd0, 1'b0, 1'b0, 1'b0);
    // Out-of-range pins still take part in the frame and loading bookkeeping.
    send_item(prll_pkg::REQ_SAMPLE, 8'd144, 8'd255, 1'b1, 1'b1, 1'b1);
    send_item(prll_pkg::REQ_LOAD_TARGET, 8'd255, 8'd255, 1'b1, 1'b0, 1'b1);
    send_item(prll_pkg::REQ_PRESENCE, 8'd200, 8'd0, 1'b0, 1'b0, 1'b0);
    send_item(prll_pkg::REQ_SAMPLE, 8'd1, 8'd50, 1'b0, 1'b1, 1'b0);
    // Now in the adjust phase: drives follow the measurement.
    send_item(prll_pkg::REQ_SAMPLE, 8'd0, 8'd255, 1'b0, 1'b0, 1'b0);
    send_item(prll_pkg::REQ_SAMPLE, 8'd143, 8'd0, 1'b0, 1'b0, 1'b0);
    send_item(prll_pkg::REQ_SET_PIN, 8'd2, 8'd0, 1'b0, 1'b0, 1'b0);
    send_item(prll_pkg::REQ_SAMPLE, 8'd2, 8'd255, 1'b0, 1'b1, 1'b0);
  endtask

  // Several register settings, the extremes and a zero adjust length among them.
  task automatic test_register_sweep();
    int sweep_set [7][4];
    int k;
    sweep_set = '{'{0, 0, 0, 1}, '{255, 255, 255, 255}, '{255, 0, 255, 0},
                  '{16, 4, 3, 2}, '{1, 13, 1, 3}, '{40, 20, 6, 5}, '{48, 13, 93, 30}};
    for (k = 0; k < 7; k++) begin
      apply_settings(sweep_set[k][0], sweep_set[k][1], sweep_set[k][2], sweep_set[k][3]);
      run_traffic(25);
    end
  endtask

  // Random settings that keep loading sessions short, then random frames.
  task automatic test_random_frames();
    int k;
    for (k = 0; k < 2; k++) begin
      apply_settings($urandom_range(0, 255), $urandom_range(0, 40), $urandom_range(0, 12),
                     $urandom_range(1, 8));
      run_traffic(45);
    end
  endtask

  // Receiver stall at the chosen idle rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    pin_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pin_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: pin %0d drive %0d loading %0d adjusting %0d",
                   out_pin, out_drive_height, out_is_loading, out_is_adjusting);
      end else begin
        want = pending_pin_results.pop_front();
        results_checked++;
        if (out_pin !== want.pin || out_drive_height !== want.drive ||
            out_is_loading !== want.loading || out_is_adjusting !== want.adjusting) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected pin %0d drive %0d loading %0d adjusting %0d, ",
                     results_checked, want.pin, want.drive, want.loading, want.adjusting,
                     "got %0d %0d %0d %0d",
                     out_pin, out_drive_height, out_is_loading, out_is_adjusting);
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    for (int i = 0; i < PIN_TOTAL; i++) begin
      drive_mirror[i] = prll_pkg::ENTRY_RESET.drive;
      target_mirror[i] = prll_pkg::ENTRY_RESET.target;
      present_mirror[i] = prll_pkg::ENTRY_RESET.present;
    end
    loading_mirror = 1'b1;
    adjust_mirror = 8'd0;
    frame_count_mirror = 8'd0;
    moving_mirror = 1'b0;
    speed_set = prll_pkg::LOAD_SPEED_RST;
    threshold_set = prll_pkg::SETTLE_THRESHOLD_RST;
    frame_limit_set = prll_pkg::MAX_LOAD_FRAMES_RST;
    adjust_len_set = prll_pkg::ADJUST_FRAMES_RST;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 35;
    recv_idle_pct = 75;
    test_directed_items();
    test_register_sweep();
    send_idle_pct = 75;
    recv_idle_pct = 35;
    test_random_frames();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames();
    wait_for_results();
    repeat (8) @(posedge clk);

    if (pending_pin_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_pin_results.size());
      mismatches += pending_pin_results.size();
    end
    $display("Sent %0d items (samples, target loads, immediate sets, presence writes) ",
             items_sent, "over %0d register settings.", settings_count);
    $display("Checked %0d result beats, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
